@@ hw/rtl/tcmm_pkg.sv @@
package tcmm_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned TypeWidth = 4;

   localparam logic [TypeWidth-1:0] TYPE_S8  = 4'd0;
   localparam logic [TypeWidth-1:0] TYPE_S16 = 4'd1;
   localparam logic [TypeWidth-1:0] TYPE_S32 = 4'd2;
   localparam logic [TypeWidth-1:0] TYPE_S64 = 4'd3;
   localparam logic [TypeWidth-1:0] TYPE_U8  = 4'd4;
   localparam logic [TypeWidth-1:0] TYPE_U16 = 4'd5;
   localparam logic [TypeWidth-1:0] TYPE_U32 = 4'd6;
   localparam logic [TypeWidth-1:0] TYPE_U64 = 4'd7;
   localparam logic [TypeWidth-1:0] TYPE_F16 = 4'd8;
   localparam logic [TypeWidth-1:0] TYPE_F32 = 4'd9;
   localparam logic [TypeWidth-1:0] TYPE_F64 = 4'd10;

   typedef struct packed {
      logic                 stats_present;
      logic [DataWidth-1:0] min_value;
      logic [DataWidth-1:0] max_value;
   } result_type;

   function automatic logic [DataWidth-1:0] width_mask(input logic [TypeWidth-1:0] t);
      logic [DataWidth-1:0] m;
      case (t)
         TYPE_S8, TYPE_U8:            m = 64'h0000_0000_0000_00FF;
         TYPE_S16, TYPE_U16, TYPE_F16: m = 64'h0000_0000_0000_FFFF;
         TYPE_S32, TYPE_U32, TYPE_F32: m = 64'h0000_0000_FFFF_FFFF;
         default:                     m = '1;
      endcase
      return m;
   endfunction

   // v must already be masked to the type width
   function automatic logic [DataWidth-1:0] order_key(input logic [DataWidth-1:0] v,
                                                      input logic [TypeWidth-1:0] t);
      logic [DataWidth-1:0] m;
      logic [DataWidth-1:0] s;
      logic [DataWidth-1:0] k;
      m = width_mask(t);
      s = m ^ (m >> 1);
      if (t <= TYPE_S64) begin
         k = v ^ s;
      end else if (t inside {[TYPE_F16:TYPE_F64]}) begin
         k = ((v & s) != '0) ? (~v & m) : (v | s);
      end else begin
         k = v;
      end
      return k;
   endfunction

endpackage

@@ hw/rtl/tcmm_req_if.sv @@
interface tcmm_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcmm_pkg::DataWidth-1:0] elem_bits;
   logic                         last_elem;

   modport source (output valid, output elem_bits, output last_elem, input ready);
   modport sink   (input valid, input elem_bits, input last_elem, output ready);
endinterface

@@ hw/rtl/tcmm_rsp_if.sv @@
interface tcmm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         stats_present;
   logic [tcmm_pkg::DataWidth-1:0] min_value;
   logic [tcmm_pkg::DataWidth-1:0] max_value;

   modport source (output valid, output stats_present, output min_value, output max_value,
                   input ready);
   modport sink   (input valid, input stats_present, input min_value, input max_value,
                   output ready);
endinterface

@@ hw/rtl/tcmm_tracker.sv @@
module tcmm_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [tcmm_pkg::TypeWidth-1:0]   elem_type,
   input  logic [tcmm_pkg::DataWidth-1:0]   elem_bits,
   input  logic                             last_elem,
   output tcmm_pkg::result_type             result
);

   logic [tcmm_pkg::DataWidth-1:0] run_min_ff, run_min_in;
   logic [tcmm_pkg::DataWidth-1:0] run_max_ff, run_max_in;
   logic                           open_ff, open_in;
   logic [tcmm_pkg::DataWidth-1:0] mask, v, rmin, rmax, k, kmin, kmax;
   logic                           known;

   always_comb begin
      mask  = tcmm_pkg::width_mask(elem_type);
      v     = elem_bits & mask;
      rmin  = run_min_ff & mask;
      rmax  = run_max_ff & mask;
      k     = tcmm_pkg::order_key(v, elem_type);
      kmin  = tcmm_pkg::order_key(rmin, elem_type);
      kmax  = tcmm_pkg::order_key(rmax, elem_type);
      known = (elem_type <= tcmm_pkg::TYPE_F64);

      if (!open_ff) begin
         run_min_in = v;
         run_max_in = v;
      end else begin
         run_min_in = (k < kmin) ? v : rmin;
         run_max_in = (k > kmax) ? v : rmax;
      end
      open_in = !last_elem;

      result.stats_present = known;
      result.min_value     = known ? run_min_in : '0;
      result.max_value     = known ? run_max_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (accept) begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
      end
   end

endmodule

@@ hw/rtl/tcmm_out_buf.sv @@
module tcmm_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tcmm_pkg::result_type push_word,
   output logic                 push_ready,
   output logic                 out_valid,
   output tcmm_pkg::result_type out_word,
   input  logic                 out_ready
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   tcmm_pkg::result_type main_word_ff, main_word_in;
   tcmm_pkg::result_type skid_word_ff, skid_word_in;
   logic                 taken;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_word   = main_word_ff;
   assign taken      = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in  = main_word_ff;
      skid_word_in  = skid_word_ff;
      if (taken) begin
         if (skid_valid_ff) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_word_in = push_word;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_word_in  = push_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = push_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid word held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("word pushed into full output buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && taken) |=> (main_valid_ff && !skid_valid_ff
                                    && main_word_ff == $past(skid_word_ff)))
      else $error("skid word not moved to output register");

endmodule

@@ hw/rtl/typed_column_min_max.sv @@
// Running min/max over a column block. One element word is taken per cycle; the
// compare and update of the running pair finish in the accepting cycle, and the
// result for the last element of a block is on rsp in the cycle after it is accepted
// when the output register is free. A two-word output buffer lets elements keep
// flowing while a result waits; the input stalls only when two results are pending.
// A type written through csr_wdata with a block open applies from the next element
// on, to the stored pair as well. An unknown type reports stats_present 0 with zeros.
module typed_column_min_max (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tcmm_pkg::TypeWidth-1:0] csr_wdata,
   tcmm_req_if.sink                       req,
   tcmm_rsp_if.source                     rsp
);

   logic [tcmm_pkg::TypeWidth-1:0] elem_type_ff;
   logic                           accept;
   logic                           buf_ready;
   tcmm_pkg::result_type           result;
   tcmm_pkg::result_type           out_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_type_ff <= tcmm_pkg::TYPE_S8;
      end else if (csr_we) begin
         elem_type_ff <= csr_wdata;
      end
   end

   assign req.ready = buf_ready;
   assign accept    = req.valid && buf_ready;

   tcmm_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .elem_type (elem_type_ff),
      .elem_bits (req.elem_bits),
      .last_elem (req.last_elem),
      .result    (result)
   );

   tcmm_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && req.last_elem),
      .push_word  (result),
      .push_ready (buf_ready),
      .out_valid  (rsp.valid),
      .out_word   (out_word),
      .out_ready  (rsp.ready)
   );

   assign rsp.stats_present = out_word.stats_present;
   assign rsp.min_value     = out_word.min_value;
   assign rsp.max_value     = out_word.max_value;

endmodule
